// ----- src/h264_rtp_fu_a_packetizer_defines.svh -----
// Assertion macros for the H.264 RTP FU-A packetizer checker
`ifndef H264_RTP_FU_A_PACKETIZER_DEFINES_SVH
`define H264_RTP_FU_A_PACKETIZER_DEFINES_SVH

// Concurrent assertion on the packetizer clock, off while reset is low
`define H264FU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that holds on every cycle the output item is presented
`define H264FU_ASSERT_OUT(lbl, expr, msg) \
    `H264FU_ASSERT(lbl, o_out_valid |-> (expr), msg)

`endif

// ----- src/h264fu_pkg.sv -----
// Shared types and constants of the H.264 RTP FU-A packetizer
`default_nettype none
package h264fu_pkg;

    localparam int MAX_FRAGMENTS = 64;
    localparam int IDX_W         = $clog2(MAX_FRAGMENTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_FRAGMENTS - 1);

    localparam int LEN_W  = 16;
    localparam int PAY_W  = 11;
    localparam int ADDR_W = 4;

    localparam logic [PAY_W-1:0] PAYLOAD_FLOOR    = 11'd2;
    localparam logic [PAY_W-1:0] PAYLOAD_CEIL     = 11'd1460;
    localparam logic [PAY_W-1:0] SINGLE_HDR_BYTES = 11'd12;
    localparam logic [PAY_W-1:0] FU_HDR_BYTES     = 11'd14;
    localparam logic [7:0]       FU_A_TYPE        = 8'd28;
    localparam logic [7:0]       FNRI_MASK        = 8'hE0;

    localparam logic [PAY_W-1:0] MP_RESET   = 11'd1400;
    localparam logic [31:0]      TS_RESET   = 32'd3600;
    localparam logic [6:0]       PT_RESET   = 7'd96;
    localparam logic [31:0]      SSRC_RESET = 32'd10;

    typedef enum logic [1:0] {
        REG_MAX_PAYLOAD  = 2'd0,
        REG_TS_INCREMENT = 2'd1,
        REG_PAYLOAD_KIND = 2'd2,
        REG_SSRC_ID      = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_FRAG
    } t_state;

    typedef struct packed {
        logic [15:0] nal_length;
        logic [7:0]  nal_header;
    } t_nal_item;

    typedef struct packed {
        logic [15:0] seq_number;
        logic [31:0] time_stamp;
        logic        marker_bit;
        logic        is_fragment;
        logic [7:0]  frag_ind;
        logic [7:0]  frag_hdr;
        logic [15:0] source_offset;
        logic [10:0] payload_bytes;
        logic [10:0] packet_bytes;
        logic        last_packet;
    } t_pkt_item;

    // Result of the shared size/compare unit
    typedef struct packed {
        logic             fits;
        logic             last;
        logic [PAY_W-1:0] size;
        logic [LEN_W-1:0] rest;
    } t_alu_res;

endpackage
`default_nettype wire

// ----- src/h264_rtp_fu_a_packetizer.sv -----
// Top level of the H.264 RTP FU-A packetizer
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-----------------------
//   in       | input     | i_in_valid / o_in_ready | t_nal_item  (NAL unit)
//   out      | output    | o_out_valid/ i_out_ready| t_pkt_item  (packet)
//   config   | input     | APB psel/penable/pready | 4 x 32-bit registers
//
// An item is taken while idle, then one packet leaves per cycle through the
// shared sizing unit unless the output stalls; a zero length item makes no packet.
// The output register frees the unit while the last packet waits to be taken.
// A stalled output holds the sequencer; no new item is taken until the last
// packet has been loaded. Reset clears sequence number and timestamp.
`default_nettype none
module h264_rtp_fu_a_packetizer
    import h264fu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire t_nal_item         i_in_data,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_pkt_item              o_out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    logic [PAY_W-1:0] mp;
    logic [31:0]      ts_inc;

    h264fu_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_mp     (mp),
        .o_ts_inc (ts_inc)
    );

    h264fu_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_mp        (mp),
        .i_ts_inc    (ts_inc)
    );

endmodule
`default_nettype wire

// ----- src/h264fu_cfg.sv -----
// APB configuration registers and payload limit clamp
`default_nettype none
module h264fu_cfg
    import h264fu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output logic      [PAY_W-1:0]  o_mp,
    output logic      [31:0]       o_ts_inc
);

    logic [PAY_W-1:0] r_max_payload;
    logic [31:0]      r_ts_inc;
    logic [6:0]       r_payload_kind;
    logic [31:0]      r_ssrc_id;
    logic             wr_en;
    t_reg_idx         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload  <= MP_RESET;
            r_ts_inc       <= TS_RESET;
            r_payload_kind <= PT_RESET;
            r_ssrc_id      <= SSRC_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MAX_PAYLOAD:  r_max_payload  <= pwdata[PAY_W-1:0];
                REG_TS_INCREMENT: r_ts_inc       <= pwdata;
                REG_PAYLOAD_KIND: r_payload_kind <= pwdata[6:0];
                REG_SSRC_ID:      r_ssrc_id      <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MAX_PAYLOAD:  prdata = {{(32-PAY_W){1'b0}}, r_max_payload};
            REG_TS_INCREMENT: prdata = r_ts_inc;
            REG_PAYLOAD_KIND: prdata = {25'd0, r_payload_kind};
            REG_SSRC_ID:      prdata = r_ssrc_id;
            default:          prdata = 32'd0;
        endcase
    end

    // Clamp the limit into the usable range
    always_comb begin
        if (r_max_payload < PAYLOAD_FLOOR) begin
            o_mp = PAYLOAD_FLOOR;
        end else if (r_max_payload > PAYLOAD_CEIL) begin
            o_mp = PAYLOAD_CEIL;
        end else begin
            o_mp = r_max_payload;
        end
    end

    assign o_ts_inc = r_ts_inc;

endmodule
`default_nettype wire

// ----- src/h264fu_alu.sv -----
// Shared compare/subtract unit: sizes one packet against the payload limit
`default_nettype none
module h264fu_alu
    import h264fu_pkg::*;
(
    input  wire logic [LEN_W-1:0] i_left,
    input  wire logic [PAY_W-1:0] i_mp,
    input  wire logic             i_first,
    input  wire logic             i_idx_end,
    output t_alu_res              o_res
);

    logic [LEN_W-1:0] mp_ext;
    logic             le;
    logic             lt;
    logic             forced;

    assign mp_ext = {{(LEN_W-PAY_W){1'b0}}, i_mp};
    assign le     = (i_left <= mp_ext);
    assign lt     = (i_left < mp_ext);
    // Bytes after the header exactly fill one fragment: split off the last byte
    assign forced = i_first && (i_left == mp_ext);

    always_comb begin
        o_res.fits = le;
        o_res.last = !forced && (le || i_idx_end);
        if (forced) begin
            o_res.size = i_mp - 11'd1;
        end else if (o_res.last && lt) begin
            o_res.size = i_left[PAY_W-1:0];
        end else begin
            o_res.size = i_mp;
        end
        o_res.rest = i_left - {{(LEN_W-PAY_W){1'b0}}, o_res.size};
    end

endmodule
`default_nettype wire

// ----- src/h264fu_engine.sv -----
// Packet sequencer: steps one NAL unit through the shared unit, one packet a cycle unless the output stalls
`default_nettype none
module h264fu_engine
    import h264fu_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire t_nal_item        i_in_data,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_pkt_item             o_out_data,
    input  wire logic [PAY_W-1:0] i_mp,
    input  wire logic [31:0]      i_ts_inc
);

    t_state           r_state;
    t_state           n_state;
    logic [LEN_W-1:0] r_left;
    logic [LEN_W-1:0] r_offs;
    logic [IDX_W-1:0] r_idx;
    logic [7:0]       r_hdr;
    logic [15:0]      r_seq;
    logic [31:0]      r_time;
    logic             r_out_valid;
    t_pkt_item        r_out;
    t_pkt_item        n_out;

    logic             accept;
    logic             start;
    logic             emit;
    logic [LEN_W-1:0] alu_left;
    logic             alu_first;
    t_alu_res         alu_res;

    h264fu_alu u_alu (
        .i_left    (alu_left),
        .i_mp      (i_mp),
        .i_first   (alu_first),
        .i_idx_end (r_idx == LAST_IDX),
        .o_res     (alu_res)
    );

    // Control outputs
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        accept     = i_in_valid && o_in_ready;
        start      = accept && (i_in_data.nal_length != '0);
        emit       = (r_state != ST_IDLE) && (!r_out_valid || i_out_ready);
        alu_left   = (r_state == ST_IDLE) ? i_in_data.nal_length : r_left;
        alu_first  = (r_state == ST_FRAG) && (r_idx == '0);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = alu_res.fits ? ST_SINGLE : ST_FRAG;
                end
            end
            ST_SINGLE: begin
                if (emit) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FRAG: begin
                if (emit && alu_res.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Packet descriptor for the current step
    always_comb begin
        n_out            = '0;
        n_out.seq_number = r_seq;
        n_out.time_stamp = r_time;
        if (r_state == ST_FRAG) begin
            n_out.marker_bit    = alu_res.last;
            n_out.is_fragment   = 1'b1;
            n_out.frag_ind      = (r_hdr & FNRI_MASK) | FU_A_TYPE;
            n_out.frag_hdr      = {alu_first, alu_res.last, 1'b0, r_hdr[4:0]};
            n_out.source_offset = r_offs;
            n_out.payload_bytes = alu_res.size;
            n_out.packet_bytes  = alu_res.size + FU_HDR_BYTES;
            n_out.last_packet   = alu_res.last;
        end else begin
            n_out.marker_bit    = 1'b1;
            n_out.payload_bytes = r_left[PAY_W-1:0];
            n_out.packet_bytes  = r_left[PAY_W-1:0] + SINGLE_HDR_BYTES;
            n_out.last_packet   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_seq       <= '0;
            r_time      <= '0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
                r_seq       <= r_seq + 16'd1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (start) begin
                r_time <= r_time + i_ts_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_left <= alu_res.fits ? i_in_data.nal_length
                                   : i_in_data.nal_length - 16'd1;
            r_hdr  <= i_in_data.nal_header;
            r_offs <= 16'd1;
            r_idx  <= '0;
        end else if (emit && (r_state == ST_FRAG)) begin
            r_left <= alu_res.rest;
            r_offs <= r_offs + {{(LEN_W-PAY_W){1'b0}}, alu_res.size};
            r_idx  <= r_idx + IDX_W'(1);
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ----- src/h264fu_checker.sv -----
// Port-level assertions for the packetizer and their bind
`default_nettype none
`include "h264_rtp_fu_a_packetizer_defines.svh"
module h264fu_checker
    import h264fu_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire t_nal_item         i_in_data,
    input wire logic              o_in_ready,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire t_pkt_item         o_out_data,
    input wire logic              psel,
    input wire logic              penable,
    input wire logic              pwrite,
    input wire logic [ADDR_W-1:0] paddr,
    input wire logic [31:0]       pwdata,
    input wire logic [31:0]       prdata,
    input wire logic              pready
);

    `H264FU_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "output item changed while stalled")
    `H264FU_ASSERT(a_busy_after_nal, i_in_valid && o_in_ready && (i_in_data.nal_length != 16'd0) |=> !o_in_ready, "new item taken while a NAL unit is in progress")
    `H264FU_ASSERT_OUT(a_marker_last, o_out_data.marker_bit == o_out_data.last_packet, "marker and last packet disagree")
    `H264FU_ASSERT_OUT(a_pkt_len, o_out_data.packet_bytes == (o_out_data.payload_bytes + (o_out_data.is_fragment ? FU_HDR_BYTES : SINGLE_HDR_BYTES)), "packet length does not match payload and header")

endmodule

bind h264_rtp_fu_a_packetizer h264fu_checker u_checker (.*);
`default_nettype wire

// ----- sim/h264fu_pkt_checker.sv -----
// Packet predictor and scoreboard for the H.264 RTP FU-A packetizer testbench
module h264fu_pkt_checker
    import h264fu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_ready,
    input  wire t_nal_item         i_in_data,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_ready,
    input  wire t_pkt_item         i_out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic              pready,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output int                     o_mismatch_count,
    output int                     o_pending
);

    logic [PAY_W-1:0] cfg_max_payload;
    logic [31:0]      cfg_ts_step;
    logic [6:0]       cfg_payload_type;
    logic [31:0]      cfg_ssrc;

    logic [15:0] next_seq;
    logic [31:0] nal_time;

    t_pkt_item expected_pkts[$];

    task automatic push_pkt(input logic last, input logic frag, input logic [7:0] ind,
                            input logic [7:0] fh, input logic [31:0] offs,
                            input logic [31:0] size);
        t_pkt_item pkt;
        pkt.seq_number    = next_seq;
        pkt.time_stamp    = nal_time;
        pkt.marker_bit    = last;
        pkt.is_fragment   = frag;
        pkt.frag_ind      = ind;
        pkt.frag_hdr      = fh;
        pkt.source_offset = offs[15:0];
        pkt.payload_bytes = size[PAY_W-1:0];
        pkt.packet_bytes  = size[PAY_W-1:0] + (frag ? FU_HDR_BYTES : SINGLE_HDR_BYTES);
        pkt.last_packet   = last;
        expected_pkts.push_back(pkt);
        next_seq = next_seq + 16'd1;
    endtask

    // Cut one NAL unit into the packets it should produce
    task automatic expand_nal(input t_nal_item nal);
        logic [31:0] len;
        logic [31:0] lim;
        logic [31:0] rem;
        logic [31:0] count;
        logic [31:0] offs;
        logic [31:0] left;
        logic [31:0] size;
        logic        split;
        logic [7:0]  ind;
        logic [4:0]  nal_type;
        len = 32'(nal.nal_length);
        if (len == 0)
            return;
        lim = 32'(cfg_max_payload);
        if (lim < 32'(PAYLOAD_FLOOR))
            lim = 32'(PAYLOAD_FLOOR);
        else if (lim > 32'(PAYLOAD_CEIL))
            lim = 32'(PAYLOAD_CEIL);
        nal_time = nal_time + cfg_ts_step;
        if (len <= lim) begin
            push_pkt(1'b1, 1'b0, 8'h00, 8'h00, 32'd0, len);
            return;
        end
        rem   = len - 1;
        count = (rem + lim - 1) / lim;
        // body exactly one limit long: split so start and end never share a fragment
        split = (count < 2);
        if (split)
            count = 2;
        if (count > MAX_FRAGMENTS)
            count = MAX_FRAGMENTS;
        ind      = (nal.nal_header & FNRI_MASK) | FU_A_TYPE;
        nal_type = nal.nal_header[4:0];
        offs     = 1;
        for (int k = 0; k < count; k++) begin
            left = len - offs;
            if (k == count - 1)
                size = (left < lim) ? left : lim;
            else
                size = split ? rem - 1 : lim;
            push_pkt(k == count - 1, 1'b1, ind,
                     {k == 0, k == count - 1, 1'b0, nal_type}, offs, size);
            offs = offs + size;
        end
    endtask

    function automatic int field_miss(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_pkt_item want;
        int        miss;
        if (!i_rst_n) begin
            cfg_max_payload  = MP_RESET;
            cfg_ts_step      = TS_RESET;
            cfg_payload_type = PT_RESET;
            cfg_ssrc         = SSRC_RESET;
            next_seq         = '0;
            nal_time         = '0;
            expected_pkts.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_pkts.size() == 0) begin
                    $error("unexpected packet item, seq_number %0d", i_out_data.seq_number);
                    o_mismatch_count++;
                end else begin
                    want = expected_pkts.pop_front();
                    miss = 0;
                    miss += field_miss("seq_number", want.seq_number, i_out_data.seq_number);
                    miss += field_miss("time_stamp", want.time_stamp, i_out_data.time_stamp);
                    miss += field_miss("marker_bit", want.marker_bit, i_out_data.marker_bit);
                    miss += field_miss("is_fragment", want.is_fragment, i_out_data.is_fragment);
                    miss += field_miss("frag_ind", want.frag_ind, i_out_data.frag_ind);
                    miss += field_miss("frag_hdr", want.frag_hdr, i_out_data.frag_hdr);
                    miss += field_miss("source_offset", want.source_offset,
                                       i_out_data.source_offset);
                    miss += field_miss("payload_bytes", want.payload_bytes,
                                       i_out_data.payload_bytes);
                    miss += field_miss("packet_bytes", want.packet_bytes,
                                       i_out_data.packet_bytes);
                    miss += field_miss("last_packet", want.last_packet, i_out_data.last_packet);
                    o_mismatch_count += miss;
                end
            end
            if (i_in_valid && i_in_ready)
                expand_nal(i_in_data);
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_MAX_PAYLOAD:  cfg_max_payload  = pwdata[PAY_W-1:0];
                    REG_TS_INCREMENT: cfg_ts_step      = pwdata;
                    REG_PAYLOAD_KIND: cfg_payload_type = pwdata[6:0];
                    REG_SSRC_ID:      cfg_ssrc         = pwdata;
                    default: ;
                endcase
            end
        end
        o_pending <= expected_pkts.size();
    end

endmodule

// ----- sim/tb.sv -----
// Stimulus and verdict for the H.264 RTP FU-A packetizer
module tb
    import h264fu_pkg::*;
();

    localparam int PHASE_ITEMS = 46;
    localparam int HOLD_CYCLES = 400;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    t_nal_item         i_in_data;
    logic              o_in_ready;
    logic              o_out_valid;
    logic              i_out_ready;
    t_pkt_item         o_out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int mismatch_count;
    int pending_count;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    bit hold_req      = 1'b0;
    int cur_limit     = 1400;

    h264_rtp_fu_a_packetizer uut (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_in_data, .o_in_ready,
        .o_out_valid, .i_out_ready, .o_out_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    h264fu_pkt_checker pkt_check (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_in_ready(o_in_ready), .i_in_data,
        .i_out_valid(o_out_valid), .i_out_ready, .i_out_data(o_out_data),
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .o_mismatch_count(mismatch_count), .o_pending(pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #48_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Packet receiver: random stalls, plus a long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            i_out_ready <= (snk_stall_pct == 0) || ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic send_nal(input logic [15:0] len, input logic [7:0] hdr);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{nal_length: len, nal_header: hdr};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Wait until every predicted packet has left and the block has settled
    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [PAY_W-1:0] mp, input logic [31:0] ts,
                                input logic [6:0] pt, input logic [31:0] ssrc);
        drain();
        write_reg(REG_MAX_PAYLOAD, 32'(mp));
        write_reg(REG_TS_INCREMENT, ts);
        write_reg(REG_PAYLOAD_KIND, 32'(pt));
        write_reg(REG_SSRC_ID, ssrc);
        cur_limit = (mp < PAYLOAD_FLOOR) ? int'(PAYLOAD_FLOOR) :
                    (mp > PAYLOAD_CEIL) ? int'(PAYLOAD_CEIL) : int'(mp);
    endtask

    // Mostly single packets, a good share near the split threshold, some long NALs
    function automatic logic [15:0] pick_length(int lim);
        int pick;
        pick = $urandom_range(19);
        if (pick == 0)
            return 16'd0;
        if (pick <= 9)
            return 16'($urandom_range(lim, 1));
        if (pick <= 13)
            return 16'(lim - 2 + $urandom_range(4));
        if (pick <= 17)
            return 16'($urandom_range(4 * lim, 1));
        if (pick == 18)
            return 16'($urandom);
        return 16'($urandom_range(65535, 60000));
    endfunction

    initial begin
        logic [15:0] len;
        int          sent;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: threshold, exact-limit split, exact multiple, long NAL
        send_nal(16'd0, 8'hFF);
        send_nal(16'd1, 8'h00);
        send_nal(16'd1400, 8'h65);
        send_nal(16'd1401, 8'hFC);
        send_nal(16'd1402, 8'h7C);
        send_nal(16'd2801, 8'h85);
        send_nal(16'd2802, 8'h41);
        send_nal(16'd65535, 8'hE7);
        send_nal(16'hAAAA, 8'h55);
        send_nal(16'h5555, 8'hAA);

        // smallest limit: tiny splits and fragment overflow
        apply_config(11'd2, 32'hFFFF_FFFF, 7'd127, 32'hFFFF_FFFF);
        send_nal(16'd1, 8'h1F);
        send_nal(16'd2, 8'h80);
        send_nal(16'd3, 8'h7F);
        send_nal(16'd4, 8'h3C);
        send_nal(16'd129, 8'hC5);
        send_nal(16'd130, 8'h25);
        apply_config(11'd0, 32'd7, 7'd0, 32'd0);
        send_nal(16'd3, 8'h9A);
        send_nal(16'd200, 8'h61);
        apply_config(11'd1, 32'd1, 7'd1, 32'd1);
        send_nal(16'd3, 8'h45);
        apply_config(11'd2047, 32'd0, 7'd64, 32'h8000_0000);
        send_nal(16'd1460, 8'h01);
        send_nal(16'd1461, 8'hE1);
        send_nal(16'd2921, 8'h5E);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    apply_config(11'($urandom_range(1460, 1024)), $urandom,
                                 7'($urandom_range(127)), $urandom);
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1: begin
                    apply_config(11'd1024, 32'd3003, 7'd127, 32'hFFFF_FFFF);
                    src_idle_pct  = 72;
                    snk_stall_pct = 0;
                end
                2: begin
                    apply_config(11'd1460, 32'hFFFF_FFFF, 7'd0, 32'd0);
                    src_idle_pct  = 0;
                    snk_stall_pct = 72;
                end
                3: begin
                    apply_config(11'($urandom_range(2047)), $urandom,
                                 7'($urandom_range(127)), $urandom);
                    src_idle_pct  = 30;
                    snk_stall_pct = 30;
                end
                4: begin
                    apply_config(11'($urandom_range(1460, 1024)), $urandom,
                                 7'($urandom_range(127)), $urandom);
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                    // hold the receiver while items keep coming so the block backs up
                    hold_req = 1'b1;
                end
                default: begin
                    apply_config(11'($urandom_range(64, 2)), $urandom,
                                 7'($urandom_range(127)), $urandom);
                    src_idle_pct  = 30;
                    snk_stall_pct = 30;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                len = pick_length(cur_limit);
                send_nal(len, 8'($urandom_range(255)));
                if (len != 0)
                    sent++;
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- h264_rtp_fu_a_packetizer.f -----
+incdir+src
src/h264fu_pkg.sv
src/h264fu_cfg.sv
src/h264fu_alu.sv
src/h264fu_engine.sv
src/h264_rtp_fu_a_packetizer.sv
src/h264fu_checker.sv
sim/h264fu_pkt_checker.sv
sim/tb.sv
